FILE: sv/ndefmp_pkg.sv
package ndefmp_pkg;

  localparam logic [2:0] SEC_HDR  = 3'd0;
  localparam logic [2:0] SEC_TLEN = 3'd1;
  localparam logic [2:0] SEC_PLEN = 3'd2;
  localparam logic [2:0] SEC_ILEN = 3'd3;
  localparam logic [2:0] SEC_TYPE = 3'd4;
  localparam logic [2:0] SEC_ID   = 3'd5;
  localparam logic [2:0] SEC_PAY  = 3'd6;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TRUNC    = 3'd1;
  localparam logic [2:0] ERR_MB       = 3'd2;
  localparam logic [2:0] ERR_AFTER_ME = 3'd3;
  localparam logic [2:0] ERR_NO_ME    = 3'd4;

  localparam int unsigned HDR_MB_BIT = 7;
  localparam int unsigned HDR_ME_BIT = 6;
  localparam int unsigned HDR_SR_BIT = 4;
  localparam int unsigned HDR_IL_BIT = 3;
  localparam logic [7:0]  HDR_TNF_MASK = 8'h07;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] section;
    logic [2:0] record_tnf;
    logic       record_end;
    logic       message_ok;
    logic [2:0] error_code;
  } result_t;

endpackage

FILE: sv/ndef_message_parser_unit.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | data_byte, last_byte
// out     | out_valid | out_stall | byte_out, section, record_tnf, record_end,
//         |           |           | message_ok, error_code
//
// one byte per cycle while in_stall is low; each result is registered in the output register,
// or in the skid register while the output is stalled; parse state is updated in the accepting cycle
// a one-entry skid register behind the output register takes one more byte
// while the output is stalled; in_stall is that skid register being full
// rst is synchronous and returns the parser to expect a first header
// a byte with last_byte set also returns the parse state to its reset value
module ndef_message_parser_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic [2:0] section,
  output logic [2:0] record_tnf,
  output logic       record_end,
  output logic       message_ok,
  output logic [2:0] error_code
);
  import ndefmp_pkg::*;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] bytes_left;
    logic        done;
  } enter_t;

  logic [2:0]  phase;
  logic [31:0] bytes_left;
  logic [7:0]  type_len_reg;
  logic [7:0]  id_len_reg;
  logic [31:0] payload_len_reg;
  logic [1:0]  len_byte_count;
  logic        short_flag;
  logic        id_present;
  logic        end_flag_seen;
  logic        expect_first;
  logic        msg_closed;
  logic [2:0]  sticky_error;
  logic [2:0]  tnf_reg;

  logic [2:0]  phase_next;
  logic [31:0] bytes_left_next;
  logic [7:0]  type_len_reg_next;
  logic [7:0]  id_len_reg_next;
  logic [31:0] payload_len_reg_next;
  logic [1:0]  len_byte_count_next;
  logic        short_flag_next;
  logic        id_present_next;
  logic        end_flag_seen_next;
  logic        expect_first_next;
  logic        msg_closed_next;
  logic [2:0]  sticky_error_next;
  logic [2:0]  tnf_reg_next;

  result_t     res;
  result_t     out_reg;
  result_t     skid_reg;
  logic        skid_valid;
  logic        in_fire;
  logic        out_fire;

  function automatic enter_t enter_content(input logic [2:0] sec, input logic [7:0] tl,
                                           input logic [7:0] il, input logic [31:0] pl);
    enter_t e;
    e.done = 1'b0;
    if (sec <= SEC_TYPE && tl != 8'd0) begin
      e.phase = SEC_TYPE;
      e.bytes_left = {24'd0, tl};
    end else if (sec <= SEC_ID && il != 8'd0) begin
      e.phase = SEC_ID;
      e.bytes_left = {24'd0, il};
    end else if (sec <= SEC_PAY && pl != 32'd0) begin
      e.phase = SEC_PAY;
      e.bytes_left = pl;
    end else begin
      e.phase = SEC_HDR;
      e.bytes_left = 32'd0;
      e.done = 1'b1;
    end
    return e;
  endfunction

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  always_comb begin
    enter_t     e;
    logic       fin;
    logic       done;
    logic [2:0] err;
    e = '0;
    fin = 1'b0;
    done = 1'b0;
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    type_len_reg_next    = type_len_reg;
    id_len_reg_next      = id_len_reg;
    payload_len_reg_next = payload_len_reg;
    len_byte_count_next  = len_byte_count;
    short_flag_next      = short_flag;
    id_present_next      = id_present;
    end_flag_seen_next   = end_flag_seen;
    expect_first_next    = expect_first;
    msg_closed_next      = msg_closed;
    tnf_reg_next         = tnf_reg;
    err                  = sticky_error;

    unique case (phase)
      SEC_HDR: begin
        if (msg_closed) begin
          if (err == ERR_NONE) err = ERR_AFTER_ME;
        end else if (data_byte[HDR_MB_BIT] != expect_first) begin
          if (err == ERR_NONE) err = ERR_MB;
        end
        end_flag_seen_next   = data_byte[HDR_ME_BIT];
        short_flag_next      = data_byte[HDR_SR_BIT];
        id_present_next      = data_byte[HDR_IL_BIT];
        tnf_reg_next         = 3'(data_byte & HDR_TNF_MASK);
        type_len_reg_next    = 8'd0;
        id_len_reg_next      = 8'd0;
        payload_len_reg_next = 32'd0;
        len_byte_count_next  = 2'd0;
        phase_next           = SEC_TLEN;
      end
      SEC_TLEN: begin
        type_len_reg_next    = data_byte;
        payload_len_reg_next = 32'd0;
        len_byte_count_next  = 2'd0;
        phase_next           = SEC_PLEN;
      end
      SEC_PLEN: begin
        payload_len_reg_next = {payload_len_reg[23:0], data_byte};
        if (short_flag) begin
          fin = 1'b1;
        end else begin
          fin = (len_byte_count == 2'd3);
          len_byte_count_next = len_byte_count + 2'd1;
        end
        if (fin) begin
          if (id_present) begin
            phase_next = SEC_ILEN;
          end else begin
            e = enter_content(SEC_TYPE, type_len_reg, id_len_reg, payload_len_reg_next);
            phase_next = e.phase;
            bytes_left_next = e.bytes_left;
            done = e.done;
          end
        end
      end
      SEC_ILEN: begin
        id_len_reg_next = data_byte;
        e = enter_content(SEC_TYPE, type_len_reg, data_byte, payload_len_reg);
        phase_next = e.phase;
        bytes_left_next = e.bytes_left;
        done = e.done;
      end
      SEC_TYPE, SEC_ID, SEC_PAY: begin
        bytes_left_next = bytes_left - 32'd1;
        if (bytes_left_next == 32'd0) begin
          e = enter_content(phase + 3'd1, type_len_reg, id_len_reg, payload_len_reg);
          phase_next = e.phase;
          bytes_left_next = e.bytes_left;
          done = e.done;
        end
      end
      default: begin
        phase_next = SEC_HDR;
      end
    endcase

    if (done) begin
      expect_first_next = 1'b0;
      msg_closed_next   = end_flag_seen_next;
    end

    if (last_byte) begin
      if (!done) begin
        if (err == ERR_NONE) err = ERR_TRUNC;
      end else if (!msg_closed_next) begin
        if (err == ERR_NONE) err = ERR_NO_ME;
      end
    end
    sticky_error_next = err;

    res.byte_out   = data_byte;
    res.section    = phase;
    res.record_tnf = tnf_reg_next;
    res.record_end = done;
    res.message_ok = last_byte && (err == ERR_NONE);
    res.error_code = err;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && last_byte)) begin
      phase           <= SEC_HDR;
      bytes_left      <= 32'd0;
      type_len_reg    <= 8'd0;
      id_len_reg      <= 8'd0;
      payload_len_reg <= 32'd0;
      len_byte_count  <= 2'd0;
      short_flag      <= 1'b0;
      id_present      <= 1'b0;
      end_flag_seen   <= 1'b0;
      expect_first    <= 1'b1;
      msg_closed      <= 1'b0;
      sticky_error    <= ERR_NONE;
      tnf_reg         <= 3'd0;
    end else if (in_fire) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      type_len_reg    <= type_len_reg_next;
      id_len_reg      <= id_len_reg_next;
      payload_len_reg <= payload_len_reg_next;
      len_byte_count  <= len_byte_count_next;
      short_flag      <= short_flag_next;
      id_present      <= id_present_next;
      end_flag_seen   <= end_flag_seen_next;
      expect_first    <= expect_first_next;
      msg_closed      <= msg_closed_next;
      sticky_error    <= sticky_error_next;
      tnf_reg         <= tnf_reg_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_fire) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_valid || out_fire) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign byte_out   = out_reg.byte_out;
  assign section    = out_reg.section;
  assign record_tnf = out_reg.record_tnf;
  assign record_end = out_reg.record_end;
  assign message_ok = out_reg.message_ok;
  assign error_code = out_reg.error_code;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output item");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> phase == SEC_HDR && sticky_error == ERR_NONE && expect_first)
    else $error("parse state not cleared after last byte");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    sticky_error != ERR_NONE && !(in_fire && last_byte) |=> sticky_error == $past(sticky_error))
    else $error("sticky error changed within a message");

  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_ok |-> error_code == ERR_NONE && record_end)
    else $error("message_ok on a faulty or open record");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(phase) && $stable(bytes_left))
    else $error("parse state moved without an input item");
`endif

endmodule

FILE: dv/tb_ndef_message_parser_unit.sv
module tb_ndef_message_parser_unit;
  import ndefmp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] byte_out;
  logic [2:0] section;
  logic [2:0] record_tnf;
  logic       record_end;
  logic       message_ok;
  logic [2:0] error_code;

  ndef_message_parser_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .byte_out(byte_out),
    .section(section),
    .record_tnf(record_tnf),
    .record_end(record_end),
    .message_ok(message_ok),
    .error_code(error_code)
  );

  always #2 clk = ~clk;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;

  result_t    parsed_q[$];
  logic [7:0] msg_q[$];

  // parser state mirror
  logic [2:0]  ps_section;
  logic [31:0] ps_remaining;
  logic [7:0]  ps_type_len;
  logic [7:0]  ps_id_len;
  logic [31:0] ps_pay_len;
  logic [1:0]  ps_len_cnt;
  logic        ps_short;
  logic        ps_has_id;
  logic        ps_me_flag;
  logic        ps_first;
  logic        ps_msg_done;
  logic [2:0]  ps_err;
  logic [2:0]  ps_tnf;

  function automatic void clear_parse_state();
    ps_section = SEC_HDR;
    ps_remaining = '0;
    ps_type_len = '0;
    ps_id_len = '0;
    ps_pay_len = '0;
    ps_len_cnt = '0;
    ps_short = 1'b0;
    ps_has_id = 1'b0;
    ps_me_flag = 1'b0;
    ps_first = 1'b1;
    ps_msg_done = 1'b0;
    ps_err = ERR_NONE;
    ps_tnf = '0;
  endfunction

  function automatic void note_error(logic [2:0] code);
    if (ps_err == ERR_NONE) ps_err = code;
  endfunction

  // returns 1 when no content section is left, i.e. the record is complete
  function automatic bit open_next_section(int from);
    if (from <= int'(SEC_TYPE) && ps_type_len != 0) begin
      ps_section = SEC_TYPE;
      ps_remaining = 32'(ps_type_len);
      return 1'b0;
    end
    if (from <= int'(SEC_ID) && ps_id_len != 0) begin
      ps_section = SEC_ID;
      ps_remaining = 32'(ps_id_len);
      return 1'b0;
    end
    if (from <= int'(SEC_PAY) && ps_pay_len != 0) begin
      ps_section = SEC_PAY;
      ps_remaining = ps_pay_len;
      return 1'b0;
    end
    ps_section = SEC_HDR;
    ps_remaining = '0;
    return 1'b1;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic last);
    result_t    r;
    logic [2:0] sec;
    bit         done;
    bit         fin;
    sec = ps_section;
    done = 1'b0;
    fin = 1'b0;
    case (sec)
      SEC_HDR: begin
        if (ps_msg_done) note_error(ERR_AFTER_ME);
        else if (b[HDR_MB_BIT] != ps_first) note_error(ERR_MB);
        ps_me_flag = b[HDR_ME_BIT];
        ps_short = b[HDR_SR_BIT];
        ps_has_id = b[HDR_IL_BIT];
        ps_tnf = 3'(b & HDR_TNF_MASK);
        ps_type_len = '0;
        ps_id_len = '0;
        ps_pay_len = '0;
        ps_len_cnt = '0;
        ps_section = SEC_TLEN;
      end
      SEC_TLEN: begin
        ps_type_len = b;
        ps_pay_len = '0;
        ps_len_cnt = '0;
        ps_section = SEC_PLEN;
      end
      SEC_PLEN: begin
        ps_pay_len = {ps_pay_len[23:0], b};
        if (ps_short) begin
          fin = 1'b1;
        end else begin
          fin = (ps_len_cnt == 2'd3);
          ps_len_cnt = ps_len_cnt + 2'd1;
        end
        if (fin) begin
          if (ps_has_id) ps_section = SEC_ILEN;
          else done = open_next_section(int'(SEC_TYPE));
        end
      end
      SEC_ILEN: begin
        ps_id_len = b;
        done = open_next_section(int'(SEC_TYPE));
      end
      SEC_TYPE, SEC_ID, SEC_PAY: begin
        ps_remaining = ps_remaining - 32'd1;
        if (ps_remaining == 0) done = open_next_section(int'(sec) + 1);
      end
      default: ps_section = SEC_HDR;
    endcase
    if (done) begin
      ps_first = 1'b0;
      ps_msg_done = ps_me_flag;
    end
    r.message_ok = 1'b0;
    if (last) begin
      if (!done) note_error(ERR_TRUNC);
      else if (!ps_msg_done) note_error(ERR_NO_ME);
      r.message_ok = (ps_err == ERR_NONE);
    end
    r.byte_out = b;
    r.section = sec;
    r.record_tnf = ps_tnf;
    r.record_end = done;
    r.error_code = ps_err;
    parsed_q = {parsed_q, r};
    if (last) clear_parse_state();
  endfunction

  task automatic send_item(logic [7:0] b, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    last_byte = last;
    do begin
      @(posedge clk);
    end while (in_stall);
    parse_byte(b, last);
    items_sent++;
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_item(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  task automatic end_traffic();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_record(bit mb, bit me, bit sr, bit il, logic [2:0] tnf,
                            int tlen, int idlen, int plen);
    logic [7:0] hdr;
    hdr = {mb, me, 1'($urandom_range(1)), sr, il, tnf};
    msg_q = {msg_q, hdr};
    msg_q = {msg_q, 8'(tlen)};
    if (sr) msg_q = {msg_q, 8'(plen)};
    else for (int k = 3; k >= 0; k--) msg_q = {msg_q, 8'(plen >> (8 * k))};
    if (il) msg_q = {msg_q, 8'(idlen)};
    repeat (tlen + (il ? idlen : 0) + plen) msg_q = {msg_q, 8'($urandom)};
  endtask

  // fault: 0 bad mb, 1 me too early or cleared, 2 no me, 3 cut short, else clean
  task automatic add_random_message();
    int n_rec;
    int fault;
    int bad_at;
    int cut;
    int tlen;
    int idlen;
    int plen;
    bit sr;
    bit il;
    bit mb;
    bit me;
    n_rec = $urandom_range(1, 4);
    fault = $urandom_range(0, 9);
    bad_at = $urandom_range(0, n_rec - 1);
    for (int r = 0; r < n_rec; r++) begin
      sr = ($urandom_range(3) != 0);
      il = $urandom_range(1);
      tlen = $urandom_range(0, 4);
      idlen = il ? $urandom_range(0, 3) : 0;
      if (!sr && $urandom_range(9) == 0) plen = $urandom_range(100, 300);
      else if ($urandom_range(29) == 0) plen = 255;
      else plen = $urandom_range(0, 12);
      mb = (r == 0);
      me = (r == n_rec - 1);
      if (fault == 0 && r == bad_at) mb = !mb;
      if (fault == 1 && r == bad_at) me = !me;
      if (fault == 2 && r == n_rec - 1) me = 1'b0;
      add_record(mb, me, sr, il, 3'($urandom), tlen, idlen, plen);
    end
    if (fault == 3 && msg_q.size() > 1) begin
      cut = $urandom_range(1, msg_q.size() - 1);
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
  endtask

  task automatic test_short_record();
    send_idle_pct = 0;
    stall_pct = 0;
    msg_q = '{8'hD1, 8'h00, 8'h00};
    send_message();
    end_traffic();
    drain();
  endtask

  task automatic test_long_form_with_id();
    msg_q = '{8'hCA, 8'h01, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h54, 8'h49,
              8'hA5, 8'h5A};
    send_message();
    end_traffic();
    drain();
  endtask

  task automatic test_faults();
    // header alone, all header bits set
    msg_q = '{8'hFF};
    send_message();
    // second record after the me record
    msg_q = '{8'hD1, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00};
    send_message();
    // record complete but no me
    msg_q = '{8'h91, 8'h00, 8'h00};
    send_message();
    // first record without mb, then cut right after the maximal long length
    msg_q = '{8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    end_traffic();
    drain();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall, int n);
    int stop_at;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 8)) msg_q = {msg_q, 8'($urandom)};
      end else begin
        add_random_message();
      end
      send_message();
    end
    end_traffic();
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(8'hD1, 1'b0);
    hold_left = 60;
    send_item(8'h01, 1'b0);
    send_item(8'h10, 1'b0);
    for (int k = 0; k < 17; k++) send_item(8'($urandom), 1'b0);
    send_item(8'h3C, 1'b1);
    end_traffic();
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (parsed_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none actual byte %0h", $time, byte_out);
      end else begin
        want = parsed_q.pop_front();
        check_field("byte_out", want.byte_out, byte_out);
        check_field("section", want.section, section);
        check_field("record_tnf", want.record_tnf, record_tnf);
        check_field("record_end", want.record_end, record_end);
        check_field("message_ok", want.message_ok, message_ok);
        check_field("error_code", want.error_code, error_code);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clear_parse_state();
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_short_record();
    test_long_form_with_id();
    test_faults();
    test_random_traffic(0, 0, 110);
    test_random_traffic(79, 0, 110);
    test_random_traffic(0, 79, 110);
    test_random_traffic(37, 37, 110);
    test_backpressure();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
